[rtl/lru_page_replacement_defines.svh]
// Assertion macros for the LRU page replacement block.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define LRUPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LRUPR_ASSERT_NEVER(lbl, cond, msg) \
	`LRUPR_ASSERT(lbl, !(cond), msg)
`else
`define LRUPR_ASSERT(lbl, prop, msg)
`define LRUPR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/lrupr_pkg.sv]
`default_nettype none
package lrupr_pkg;

	localparam int unsigned MAX_FRAMES_DEF = 8;
	localparam int unsigned PAGE_BITS_DEF  = 16;
	localparam int unsigned FRAMES_W       = 4;
	localparam int unsigned FAULT_W        = 32;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(8);

	// clamp the frames register into 1 .. max_frames
	function automatic int unsigned eff_frames(logic [FRAMES_W-1:0] frames,
			int unsigned max_frames);
		int unsigned f;
		f = 32'(frames);
		if (f == 0)
			return 1;
		if (f > max_frames)
			return max_frames;
		return f;
	endfunction

endpackage
`default_nettype wire

[rtl/lru_page_replacement.sv]
`default_nettype none
// LRU page replacement unit. Each input item is one page reference; the block
// keeps up to frames_in_use resident pages ordered from most to least recently
// used. A hit moves the page to the front, a miss raises page_fault, bumps the
// saturating fault_total and inserts the page at the front, evicting and
// reporting the least recently used page when all frames in use are taken.
// Every reference yields exactly one result item. The block takes one item per
// cycle unless the result channel stalls; each item waits in the input register
// while the parallel tag compare and recency-stack shift run, which together
// set the clock rate, and then passes to the result register. Write cfg_wr_data to
// set frames_in_use (0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES)
// only while the block is idle; shrinking it drops the oldest resident pages
// without reporting them. Resident pages read as undefined until referenced.
`include "lru_page_replacement_defines.svh"
module lru_page_replacement #(
	parameter int unsigned MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
	parameter int unsigned PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_wr_en,
	input  wire logic [lrupr_pkg::FRAMES_W-1:0] cfg_wr_data,
	// reference channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [PAGE_BITS-1:0]           page_number,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                page_fault,
	output logic                                evict_valid,
	output logic [PAGE_BITS-1:0]                evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0]       fault_total
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	typedef logic [PAGE_BITS-1:0] page_t;

	// configuration and bookkeeping
	logic [lrupr_pkg::FRAMES_W-1:0] frames_q;
	logic [CNT_W-1:0]               count_q;
	logic [lrupr_pkg::FAULT_W-1:0]  fault_q;
	logic [CNT_W-1:0]               lim;
	logic [CNT_W-1:0]               lim_wr;

	// recency stack, position 0 is the most recently used page
	page_t                          stack_q [MAX_FRAMES];
	page_t                          stack_d [MAX_FRAMES];

	// input register
	logic                           valid_s1;
	page_t                          page_s1;

	// result register
	logic                           out_valid_q;
	logic                           page_fault_q;
	logic                           evict_q;
	page_t                          victim_q;

	logic                           adv;
	logic                           in_take;
	logic [MAX_FRAMES-1:0]          match;
	logic [MAX_FRAMES-1:0]          shift;
	logic                           hit;
	logic                           full;
	logic [IDX_W-1:0]               lru_idx;

	assign lim    = CNT_W'(lrupr_pkg::eff_frames(frames_q, MAX_FRAMES));
	assign lim_wr = CNT_W'(lrupr_pkg::eff_frames(cfg_wr_data, MAX_FRAMES));

	// Advance the item in the input register whenever the result register is
	// free or being emptied this cycle; hold the input side otherwise.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	assign full    = (count_q == lim);
	assign lru_idx = IDX_W'(lim - CNT_W'(1));

	// Parallel compare against the resident positions, then work out which
	// positions take their neighbour's page. On a hit everything up to the
	// matching position moves down; on a miss everything up to the last
	// occupied (or last usable) position moves down.
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match[i] = (count_q > CNT_W'(i)) && (stack_q[i] == page_s1);
		end
		hit = |match;
		shift = '0;
		for (int i = 1; i < MAX_FRAMES; i++) begin
			if (hit)
				shift[i] = ((match >> i) != '0);
			else
				shift[i] = (count_q >= CNT_W'(i)) && (lim > CNT_W'(i));
		end
		stack_d[0] = page_s1;
		for (int i = 1; i < MAX_FRAMES; i++) begin
			stack_d[i] = shift[i] ? stack_q[i-1] : stack_q[i];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			page_s1 <= page_number;
		end
	end

	// control state: frames register, occupancy, fault counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q    <= lrupr_pkg::FRAMES_RESET;
			count_q     <= '0;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				frames_q <= cfg_wr_data;
				// drop the oldest pages silently when the limit shrinks
				if (count_q > lim_wr)
					count_q <= lim_wr;
			end else if (adv && !hit && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (adv && !hit && (fault_q != '1))
				fault_q <= fault_q + 1'b1;
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// recency stack and result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				stack_q[i] <= stack_d[i];
			end
			page_fault_q <= !hit;
			evict_q      <= !hit && full;
			victim_q     <= (!hit && full) ? stack_q[lru_idx] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign page_fault   = page_fault_q;
	assign evict_valid  = evict_q;
	assign evicted_page = victim_q;
	// the counter only moves when a new result is loaded, so it tracks the result
	assign fault_total  = fault_q;

	`LRUPR_ASSERT(a_count_in_limit, count_q <= lim,
		"resident count above frame limit")
	`LRUPR_ASSERT_NEVER(a_evict_needs_fault, out_valid_q && evict_q && !page_fault_q,
		"eviction reported on a hit")
	`LRUPR_ASSERT(a_hit_keeps_count, (adv && hit) |=> (fault_q == $past(fault_q)),
		"fault counter moved on a hit")

endmodule
`default_nettype wire
